// ===== sv/bounded_array_list_macros.svh =====
// Assertion macros used by the bounded array list checker.
`ifndef BOUNDED_ARRAY_LIST_MACROS_SVH
`define BOUNDED_ARRAY_LIST_MACROS_SVH

// Clocked check, switched off while reset is asserted.
`define BAL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked check that is also evaluated during reset.
`define BAL_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/bal_pkg.sv =====
// Types, codes and constants of the bounded array list.
package bal_pkg;

  localparam int unsigned DEPTH_DEF = 64;
  localparam int unsigned CNT_W     = 7;
  localparam int unsigned DATA_W    = 32;
  localparam logic [CNT_W-1:0] CAP_RST = 7'd64;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FULL      = 2'd2
  } st_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SH_RD,
    S_SH_WR,
    S_RD_CAP,
    S_FIN
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic decide;
    logic wr_shift;
    logic wr_val;
    logic idx_step;
    logic cnt_inc;
    logic cnt_dec;
    logic data_cap;
    logic out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    op_t  op;
    logic ok;
    logic at_end;
    logic out_free;
  } sts_t;

endpackage

// ===== sv/bal_in_if.sv =====
// Request channel of the bounded array list.
interface bal_in_if import bal_pkg::*; ();
  logic                     valid;
  logic                     ready;
  op_t                      operation;
  logic [CNT_W-1:0]         position;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, operation, position, value, input ready);
  modport sink   (input valid, operation, position, value, output ready);
endinterface

// ===== sv/bal_out_if.sv =====
// Result channel of the bounded array list.
interface bal_out_if import bal_pkg::*; ();
  logic                     valid;
  logic                     ready;
  st_t                      status;
  logic signed [DATA_W-1:0] read_data;
  logic [CNT_W-1:0]         count;
  logic                     is_full;
  logic                     is_empty;

  modport source (output valid, status, read_data, count, is_full, is_empty, input ready);
  modport sink   (input valid, status, read_data, count, is_full, is_empty, output ready);
endinterface

// ===== sv/bounded_array_list.sv =====
// Top level of the bounded array list: sequencer plus datapath.
//
// An ordered list of signed 32-bit words in a DEPTH-entry store.
// in_ch carries one request per transaction: operation (insert, remove,
// read, clear), position and value. out_ch returns exactly one result per
// request: status, read_data, count, is_full, is_empty.
// cfg_we/cfg_wdata write the capacity register (reset 64); the user must
// write it only while idle, which the block itself does not enforce.
// Sequence per request: decide; then clear and refused requests go straight to
// the result hand-off, a read captures the stored word, and insert or remove
// run the shift loop, each moved entry a read and then a write of the store
// (entries moved: insert count - position, remove count - 1 - position).
// A new request is accepted only once the previous one has handed its result
// to the output register.
// Reset clears count and out valid and loads capacity 64; stored words stay
// undefined but are never returned. A stalled receiver holds the result in the
// output register; one more request is accepted and processed meanwhile,
// and it waits at the end until the output register frees up.
module bounded_array_list import bal_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata,
  bal_in_if.sink           in_ch,
  bal_out_if.source        out_ch
);

  cmd_t cmd;   // sequencer commands
  sts_t sts;   // datapath status

  // state machine: decide, shift loop, read capture, result hand-off
  bal_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // store, count, capacity and the output register
  bal_dpath #(.DEPTH(DEPTH)) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_operation  (in_ch.operation),
    .in_position   (in_ch.position),
    .in_value      (in_ch.value),
    .cmd           (cmd),
    .sts           (sts),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .out_status    (out_ch.status),
    .out_read_data (out_ch.read_data),
    .out_count     (out_ch.count),
    .out_is_full   (out_ch.is_full),
    .out_is_empty  (out_ch.is_empty)
  );

endmodule

// ===== sv/bal_ctrl.sv =====
// Sequencer of the bounded array list.
module bal_ctrl import bal_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (!sts.ok || sts.op == OP_CLEAR) state_nxt = S_FIN;
        else if (sts.op == OP_READ)        state_nxt = S_RD_CAP;
        else                               state_nxt = S_SH_RD;
      end
      S_SH_RD: begin
        state_nxt = sts.at_end ? S_FIN : S_SH_WR;
      end
      S_SH_WR:  state_nxt = S_SH_RD;
      S_RD_CAP: state_nxt = S_FIN;
      S_FIN: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        // no transaction is taken while reset is held
        in_ready = rst_n;
        cmd.load = in_valid;
      end
      S_DECIDE: cmd.decide = 1'b1;
      S_SH_RD: begin
        if (sts.at_end) begin
          cmd.wr_val  = (sts.op == OP_INSERT);
          cmd.cnt_inc = (sts.op == OP_INSERT);
          cmd.cnt_dec = (sts.op == OP_REMOVE);
        end
      end
      S_SH_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.idx_step = 1'b1;
      end
      S_RD_CAP: cmd.data_cap = 1'b1;
      S_FIN:    cmd.out_load = sts.out_free;
      default:  cmd = '0;
    endcase
  end

endmodule

// ===== sv/bal_dpath.sv =====
// Entry store, count, capacity and result register of the bounded array list.
module bal_dpath import bal_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CNT_W-1:0]         cfg_wdata,
  input  op_t                      in_operation,
  input  logic [CNT_W-1:0]         in_position,
  input  logic signed [DATA_W-1:0] in_value,
  input  cmd_t                     cmd,
  output sts_t                     sts,
  input  logic                     out_ready,
  output logic                     out_valid,
  output st_t                      out_status,
  output logic signed [DATA_W-1:0] out_read_data,
  output logic [CNT_W-1:0]         out_count,
  output logic                     out_is_full,
  output logic                     out_is_empty
);

  localparam int unsigned AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CAP_LIM = (DEPTH > 127) ? 127 : DEPTH;

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rdata_r;
  logic [AW-1:0]     raddr, waddr;
  logic [DATA_W-1:0] wdata;
  logic              we;

  op_t               op_r;
  logic [CNT_W-1:0]  pos_r;
  logic [DATA_W-1:0] val_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  cap_r, cap_eff;
  logic [CNT_W-1:0]  idx_dn, idx_up;
  logic [CNT_W:0]    idx_p1;
  st_t               status_r, status_c;
  logic [DATA_W-1:0] data_r;
  logic              out_valid_r;
  st_t               o_status_r;
  logic [DATA_W-1:0] o_data_r;
  logic [CNT_W-1:0]  o_count_r;
  logic              o_full_r, o_empty_r;
  logic              full_c;

  // capacity clamped to 1..min(DEPTH, 127)
  always_comb begin
    cap_eff = cap_r;
    if (cap_r == '0)                    cap_eff = 7'd1;
    else if (cap_r > CNT_W'(CAP_LIM))   cap_eff = CNT_W'(CAP_LIM);
  end

  assign full_c = (count_r >= cap_eff);

  always_comb begin
    status_c = ST_OK;
    case (op_r) inside
      OP_INSERT: begin
        if (pos_r > count_r) status_c = ST_BAD_INDEX;
        else if (full_c)     status_c = ST_FULL;
      end
      OP_REMOVE, OP_READ: begin
        if (pos_r >= count_r) status_c = ST_BAD_INDEX;
      end
      default: status_c = ST_OK;
    endcase
  end

  assign idx_dn = idx_r - 7'd1;
  assign idx_up = idx_r + 7'd1;
  assign idx_p1 = {1'b0, idx_r} + 8'd1;

  always_comb begin
    case (op_r)
      OP_INSERT: raddr = AW'(idx_dn);
      OP_REMOVE: raddr = AW'(idx_up);
      default:   raddr = AW'(pos_r);
    endcase
  end

  assign waddr = AW'(idx_r);
  assign wdata = cmd.wr_val ? val_r : rdata_r;
  assign we    = cmd.wr_val | cmd.wr_shift;

  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    rdata_r <= mem_r[raddr];
  end

  always_comb begin
    sts.op       = op_r;
    sts.ok       = (status_c == ST_OK);
    sts.at_end   = (op_r == OP_INSERT) ? (idx_r == pos_r) : (idx_p1 == {1'b0, count_r});
    sts.out_free = !out_valid_r || out_ready;
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.decide && op_r == OP_CLEAR) count_nxt = '0;
    else if (cmd.cnt_inc)               count_nxt = count_r + 7'd1;
    else if (cmd.cnt_dec)               count_nxt = count_r - 7'd1;
  end

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.decide)        idx_nxt = (op_r == OP_INSERT) ? count_r : pos_r;
    else if (cmd.idx_step) idx_nxt = (op_r == OP_INSERT) ? idx_dn : idx_up;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cap_r       <= CAP_RST;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cfg_we) cap_r <= cfg_wdata;
      if (cmd.out_load)  out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.load) begin
      op_r  <= in_operation;
      pos_r <= in_position;
      val_r <= in_value;
    end
    if (cmd.decide) begin
      status_r <= status_c;
      data_r   <= '0;
    end else if (cmd.data_cap) begin
      data_r   <= rdata_r;
    end
    if (cmd.out_load) begin
      o_status_r <= status_r;
      o_data_r   <= data_r;
      o_count_r  <= count_r;
      o_full_r   <= full_c;
      o_empty_r  <= (count_r == '0);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = o_status_r;
  assign out_read_data = o_data_r;
  assign out_count     = o_count_r;
  assign out_is_full   = o_full_r;
  assign out_is_empty  = o_empty_r;

endmodule

// ===== sv/bal_checker.sv =====
// Port-level checks of the bounded array list, bound to the top level.
`include "bounded_array_list_macros.svh"

module bal_checker import bal_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     out_valid,
  input logic                     out_ready,
  input st_t                      out_status,
  input logic signed [DATA_W-1:0] out_read_data,
  input logic [CNT_W-1:0]         out_count,
  input logic                     out_is_full,
  input logic                     out_is_empty
);

  `BAL_ASSERT(a_empty_flag, out_valid |-> (out_is_empty == (out_count == '0)), "empty flag disagrees with count")
  `BAL_ASSERT(a_empty_not_full, (out_valid && out_is_empty) |-> !out_is_full, "empty list reported full")
  `BAL_ASSERT(a_fail_no_data, (out_valid && out_status != ST_OK) |-> (out_read_data == '0), "failed transaction returned data")
  `BAL_ASSERT(a_stall_hold, (out_valid && !out_ready) |=> (out_valid && $stable(out_count) && $stable(out_status) && $stable(out_read_data)), "result changed while stalled")
  `BAL_ASSERT_RST(a_rst_idle, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind bounded_array_list bal_checker u_bal_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_status    (out_ch.status),
  .out_read_data (out_ch.read_data),
  .out_count     (out_ch.count),
  .out_is_full   (out_ch.is_full),
  .out_is_empty  (out_ch.is_empty)
);
